// ===== rtl/gbed_pkg.sv =====
// shared types and constants for the gated burst event detector
package gbed_pkg;

    // request codes
    localparam logic [1:0] REQ_STICK   = 2'd0;
    localparam logic [1:0] REQ_POINTER = 2'd1;
    localparam logic [1:0] REQ_QUERY   = 2'd2;
    localparam logic [1:0] REQ_CLEAR   = 2'd3;

    // pointer event kinds
    localparam logic [1:0] KIND_MOVE   = 2'd0;
    localparam logic [1:0] KIND_WHEEL  = 2'd1;
    localparam logic [1:0] KIND_HWHEEL = 2'd2;
    localparam logic [1:0] KIND_OTHER  = 2'd3;

    // configuration register indexes
    localparam int          CFG_IDX_BITS    = 3;
    localparam int          CFG_DATA_BITS   = 64;
    localparam logic [2:0]  CFG_ENABLED     = 3'd0;
    localparam logic [2:0]  CFG_GRACE_MS    = 3'd1;
    localparam logic [2:0]  CFG_WINDOW_MS   = 3'd2;
    localparam logic [2:0]  CFG_HITS_NEEDED = 3'd3;
    localparam logic [2:0]  CFG_HOLD_MS     = 3'd4;
    localparam logic [2:0]  CFG_OWN_TAG     = 3'd5;

    // register reset values
    localparam logic [15:0] GRACE_MS_RST    = 16'd200;
    localparam logic [15:0] WINDOW_MS_RST   = 16'd1000;
    localparam logic [7:0]  HITS_NEEDED_RST = 8'd6;
    localparam logic [15:0] HOLD_MS_RST     = 16'd3000;

    localparam logic [7:0]  HIT_COUNT_MAX   = 8'd255;

    // one input item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [1:0]  event_kind;
        logic        injected;
        logic [63:0] extra_tag;
    } t_item;

endpackage

// ===== rtl/gbed_in_stage.sv =====
// input register stage of the detector
module gbed_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  gbed_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output gbed_pkg::t_item o_item
);

    logic           r_valid;
    logic           n_valid;
    gbed_pkg::t_item r_item;
    logic           w_load;

    // stage refills when empty or when its item moves on
    assign o_stall = r_valid && !i_ready;
    assign w_load  = i_valid && !o_stall;
    assign n_valid = w_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/gbed_core.sv =====
// configuration, detector state update and result register
module gbed_core #(
    parameter int TIME_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gbed_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [gbed_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  gbed_pkg::t_item                    i_item,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_external_active,
    output logic [7:0]                        o_hits_in_window
);

    // configuration
    logic        r_enabled;
    logic [15:0] r_grace_ms;
    logic [15:0] r_window_ms;
    logic [7:0]  r_hits_needed;
    logic [15:0] r_hold_ms;
    logic [63:0] r_own_tag;

    // detector state
    logic [TIME_BITS-1:0] r_last_stick, n_last_stick;
    logic                 r_stick_seen, n_stick_seen;
    logic [TIME_BITS-1:0] r_win_start, n_win_start;
    logic [7:0]           r_hit_count, n_hit_count;
    logic [TIME_BITS-1:0] r_last_detect, n_last_detect;
    logic                 r_detect_seen, n_detect_seen;

    // result
    logic       r_out_valid, n_out_valid;
    logic       r_active, n_active;
    logic [7:0] r_hits;

    logic                 w_fire;
    logic                 w_disable;
    logic [63:0]          w_now_ext;
    logic [TIME_BITS-1:0] w_now;
    logic [63:0]          w_grace_ext, w_window_ext, w_hold_ext;
    logic [TIME_BITS-1:0] w_since_stick, w_since_win, w_since_detect;
    logic                 w_hit;
    logic                 w_stale;
    logic [7:0]           w_count_inc;
    logic                 w_trigger;

    assign o_ready = !r_out_valid || !i_stall;
    assign w_fire  = i_valid && o_ready;

    // time is taken modulo 2^TIME_BITS
    assign w_now_ext    = {32'd0, i_item.now_ms};
    assign w_now        = w_now_ext[TIME_BITS-1:0];
    assign w_grace_ext  = {48'd0, r_grace_ms};
    assign w_window_ext = {48'd0, r_window_ms};
    assign w_hold_ext   = {48'd0, r_hold_ms};

    assign w_since_stick  = w_now - r_last_stick;
    assign w_since_win    = w_now - r_win_start;
    assign w_since_detect = w_now - r_last_detect;

    assign w_hit = (i_item.event_kind != gbed_pkg::KIND_OTHER) && i_item.injected
                   && (i_item.extra_tag != r_own_tag) && r_enabled && r_stick_seen
                   && (w_since_stick <= w_grace_ext[TIME_BITS-1:0]);
    assign w_stale     = w_since_win > w_window_ext[TIME_BITS-1:0];
    assign w_count_inc = (r_hit_count == gbed_pkg::HIT_COUNT_MAX) ? r_hit_count
                                                                  : r_hit_count + 8'd1;
    assign w_trigger   = (i_item.req_type == gbed_pkg::REQ_POINTER) && w_hit && !w_stale
                         && (w_count_inc >= r_hits_needed);

    assign w_disable = i_cfg_we && (i_cfg_idx == gbed_pkg::CFG_ENABLED)
                       && r_enabled && !i_cfg_data[0];

    always_comb begin
        n_last_stick  = r_last_stick;
        n_stick_seen  = r_stick_seen;
        n_win_start   = r_win_start;
        n_hit_count   = r_hit_count;
        n_last_detect = r_last_detect;
        n_detect_seen = r_detect_seen;
        n_active      = r_active;
        if (w_fire) begin
            case (i_item.req_type)
                gbed_pkg::REQ_STICK: begin
                    n_last_stick = w_now;
                    n_stick_seen = 1'b1;
                end
                gbed_pkg::REQ_POINTER: begin
                    if (w_hit) begin
                        if (w_stale) begin
                            n_win_start = w_now;
                            n_hit_count = 8'd1;
                        end else begin
                            n_hit_count = w_count_inc;
                        end
                    end
                    if (w_trigger) begin
                        n_last_detect = w_now;
                        n_detect_seen = 1'b1;
                    end
                end
                gbed_pkg::REQ_CLEAR: begin
                    n_hit_count   = 8'd0;
                    n_last_detect = '0;
                    n_detect_seen = 1'b0;
                end
                default: begin
                end
            endcase
            // a fresh trigger leaves zero elapsed time
            if (i_item.req_type == gbed_pkg::REQ_CLEAR) begin
                n_active = 1'b0;
            end else if (w_trigger) begin
                n_active = 1'b1;
            end else begin
                n_active = r_detect_seen && (w_since_detect <= w_hold_ext[TIME_BITS-1:0]);
            end
        end
        // turning the block off drops any detection
        if (w_disable) begin
            n_hit_count   = 8'd0;
            n_last_detect = '0;
            n_detect_seen = 1'b0;
        end
    end

    assign n_out_valid = w_fire || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b0;
            r_grace_ms    <= gbed_pkg::GRACE_MS_RST;
            r_window_ms   <= gbed_pkg::WINDOW_MS_RST;
            r_hits_needed <= gbed_pkg::HITS_NEEDED_RST;
            r_hold_ms     <= gbed_pkg::HOLD_MS_RST;
            r_own_tag     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gbed_pkg::CFG_ENABLED:     r_enabled     <= i_cfg_data[0];
                gbed_pkg::CFG_GRACE_MS:    r_grace_ms    <= i_cfg_data[15:0];
                gbed_pkg::CFG_WINDOW_MS:   r_window_ms   <= i_cfg_data[15:0];
                gbed_pkg::CFG_HITS_NEEDED: r_hits_needed <= i_cfg_data[7:0];
                gbed_pkg::CFG_HOLD_MS:     r_hold_ms     <= i_cfg_data[15:0];
                gbed_pkg::CFG_OWN_TAG:     r_own_tag     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stick  <= '0;
            r_stick_seen  <= 1'b0;
            r_win_start   <= '0;
            r_hit_count   <= 8'd0;
            r_last_detect <= '0;
            r_detect_seen <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_last_stick  <= n_last_stick;
            r_stick_seen  <= n_stick_seen;
            r_win_start   <= n_win_start;
            r_hit_count   <= n_hit_count;
            r_last_detect <= n_last_detect;
            r_detect_seen <= n_detect_seen;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_active <= n_active;
            r_hits   <= n_hit_count;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_external_active = r_active;
    assign o_hits_in_window  = r_hits;

endmodule

// ===== rtl/gated_burst_event_detector.sv =====
// an input transfer passes the input register and then the result register before its result is valid
// throughput: one item per cycle while the receiver does not stall; the single-pass state update in the core sets this
// a result waiting on i_stall holds the core; the input register then takes at most
// one more transfer before o_stall rises
// reset: synchronous active-low i_rst_n empties both stages, zeroes the detector
// state and loads the register defaults; ready in the cycle after reset
module gated_burst_event_detector #(
    parameter int TIME_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gbed_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [gbed_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_req_type,
    input  logic [31:0]                       i_now_ms,
    input  logic [1:0]                        i_event_kind,
    input  logic                              i_injected,
    input  logic [63:0]                       i_extra_tag,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_external_active,
    output logic [7:0]                        o_hits_in_window
);

    gbed_pkg::t_item w_in_item;
    gbed_pkg::t_item w_s1_item;
    logic           w_s1_valid;
    logic           w_core_ready;

    assign w_in_item.req_type   = i_req_type;
    assign w_in_item.now_ms     = i_now_ms;
    assign w_in_item.event_kind = i_event_kind;
    assign w_in_item.injected   = i_injected;
    assign w_in_item.extra_tag  = i_extra_tag;

    gbed_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (w_in_item),
        .o_valid (w_s1_valid),
        .i_ready (w_core_ready),
        .o_item  (w_s1_item)
    );

    gbed_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (w_s1_valid),
        .o_ready           (w_core_ready),
        .i_item            (w_s1_item),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_external_active (o_external_active),
        .o_hits_in_window  (o_hits_in_window)
    );

endmodule

// ===== verif/tb_gated_burst_event_detector.sv =====
`timescale 1ns / 100ps
// testbench for the gated burst event detector: directed and random request streams, scoreboard
module tb_gated_burst_event_detector;

    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         HOLDOFF_AT     = 300;
    localparam int         HOLDOFF_CYCLES = 90;
    localparam int         QUIET_FROM     = 420;
    localparam int         QUIET_TO       = 520;
    localparam int         IDLE_PCT       = 16;
    localparam logic [2:0] CFG_SPARE_6    = 3'd6;
    localparam logic [2:0] CFG_SPARE_7    = 3'd7;

    typedef struct packed {
        logic       active;
        logic [7:0] hits;
    } t_detect_result;

    logic                               clk      = 1'b0;
    logic                               rst_n    = 1'b0;
    logic                               cfg_we   = 1'b0;
    logic [gbed_pkg::CFG_IDX_BITS-1:0]  cfg_idx  = '0;
    logic [gbed_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                               drv_valid = 1'b0;
    gbed_pkg::t_item                    drv_item  = '0;
    logic                               rx_stall  = 1'b0;
    logic                               blk_stall;
    logic                               res_valid;
    logic                               res_active;
    logic [7:0]                         res_hits;

    gated_burst_event_detector uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_valid           (drv_valid),
        .o_stall           (blk_stall),
        .i_req_type        (drv_item.req_type),
        .i_now_ms          (drv_item.now_ms),
        .i_event_kind      (drv_item.event_kind),
        .i_injected        (drv_item.injected),
        .i_extra_tag       (drv_item.extra_tag),
        .o_valid           (res_valid),
        .i_stall           (rx_stall),
        .o_external_active (res_active),
        .o_hits_in_window  (res_hits)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor copy of registers and detector state
    logic        m_enabled;
    logic [15:0] m_grace;
    logic [15:0] m_window;
    logic [7:0]  m_hits_needed;
    logic [15:0] m_hold;
    logic [63:0] m_own_tag;
    logic [31:0] m_last_stick;
    logic        m_stick_seen;
    logic [31:0] m_win_start;
    logic [7:0]  m_hit_count;
    logic [31:0] m_last_detect;
    logic        m_detect_seen;

    gbed_pkg::t_item pending_items[$];
    t_detect_result  expected_results[$];

    int          n_accepted = 0;
    int          n_results  = 0;
    int          n_active   = 0;
    int          n_fail     = 0;
    int          n_settings = 0;
    int          cycles     = 0;
    int          holdoff_left = 0;
    logic        holdoff_done = 1'b0;
    logic [7:0]  peak_hits  = '0;
    logic [31:0] t_cur      = '0;

    function automatic void clear_detection();
        m_hit_count   = '0;
        m_last_detect = '0;
        m_detect_seen = 1'b0;
    endfunction

    function automatic void model_reset();
        m_enabled     = 1'b0;
        m_grace       = gbed_pkg::GRACE_MS_RST;
        m_window      = gbed_pkg::WINDOW_MS_RST;
        m_hits_needed = gbed_pkg::HITS_NEEDED_RST;
        m_hold        = gbed_pkg::HOLD_MS_RST;
        m_own_tag     = '0;
        m_last_stick  = '0;
        m_stick_seen  = 1'b0;
        m_win_start   = '0;
        clear_detection();
    endfunction

    function automatic void model_write(logic [2:0] idx, logic [63:0] d);
        case (idx)
            gbed_pkg::CFG_ENABLED: begin
                if (m_enabled && !d[0])
                    clear_detection();
                m_enabled = d[0];
            end
            gbed_pkg::CFG_GRACE_MS:    m_grace       = d[15:0];
            gbed_pkg::CFG_WINDOW_MS:   m_window      = d[15:0];
            gbed_pkg::CFG_HITS_NEEDED: m_hits_needed = d[7:0];
            gbed_pkg::CFG_HOLD_MS:     m_hold        = d[15:0];
            gbed_pkg::CFG_OWN_TAG:     m_own_tag     = d;
            default: ;
        endcase
    endfunction

    function automatic t_detect_result predict_detect(gbed_pkg::t_item it);
        t_detect_result r;
        logic           hit;
        logic [31:0]    since;
        case (it.req_type)
            gbed_pkg::REQ_STICK: begin
                m_last_stick = it.now_ms;
                m_stick_seen = 1'b1;
            end
            gbed_pkg::REQ_POINTER: begin
                since = it.now_ms - m_last_stick;
                hit = (it.event_kind != gbed_pkg::KIND_OTHER) && it.injected &&
                      (it.extra_tag != m_own_tag) && m_enabled && m_stick_seen &&
                      (since <= {16'd0, m_grace});
                if (hit) begin
                    since = it.now_ms - m_win_start;
                    if (since > {16'd0, m_window}) begin
                        // stale window restarts, no trigger on this hit
                        m_win_start = it.now_ms;
                        m_hit_count = 8'd1;
                    end else begin
                        if (m_hit_count != gbed_pkg::HIT_COUNT_MAX)
                            m_hit_count = m_hit_count + 8'd1;
                        if (m_hit_count >= m_hits_needed) begin
                            m_last_detect = it.now_ms;
                            m_detect_seen = 1'b1;
                        end
                    end
                end
            end
            gbed_pkg::REQ_CLEAR: clear_detection();
            default: ;
        endcase
        since    = it.now_ms - m_last_detect;
        r.active = m_detect_seen && (since <= {16'd0, m_hold});
        r.hits   = m_hit_count;
        return r;
    endfunction

    function automatic logic [63:0] rand_tag();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] foreign_tag();
        logic [63:0] t;
        t = rand_tag();
        if (t == m_own_tag)
            t[0] = ~t[0];
        return t;
    endfunction

    function automatic int unsigned pace();
        int unsigned lim;
        lim = (m_grace < m_window) ? m_grace : m_window;
        return lim / 6;
    endfunction

    function automatic logic quiet();
        return n_accepted >= QUIET_FROM && n_accepted < QUIET_TO;
    endfunction

    task automatic push_item(logic [1:0] req, logic [31:0] now, logic [1:0] kind, logic inj,
                             logic [63:0] tag);
        gbed_pkg::t_item it;
        it.req_type   = req;
        it.now_ms     = now;
        it.event_kind = kind;
        it.injected   = inj;
        it.extra_tag  = tag;
        pending_items.push_back(it);
    endtask

    // stick, query or clear with random pointer fields, which the block ignores
    task automatic push_plain(logic [1:0] req, logic [31:0] now);
        push_item(req, now, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand_tag());
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] d);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_write(idx, d);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || drv_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic randomize_regs();
        write_reg(gbed_pkg::CFG_GRACE_MS, 64'($urandom_range(0, 1500)));
        write_reg(gbed_pkg::CFG_WINDOW_MS, 64'($urandom_range(1, 3000)));
        write_reg(gbed_pkg::CFG_HITS_NEEDED, 64'($urandom_range(1, 12)));
        write_reg(gbed_pkg::CFG_HOLD_MS, 64'($urandom_range(0, 5000)));
        write_reg(gbed_pkg::CFG_OWN_TAG, rand_tag());
        n_settings++;
    endtask

    // stick-led bursts of pointer events with some noise mixed in
    task automatic gen_traffic(int n, int unsigned dt_max);
        int unsigned roll;
        logic [1:0]  kind;
        logic        inj;
        logic [63:0] tag;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                t_cur += $urandom_range(0, dt_max);
                push_plain(gbed_pkg::REQ_STICK, t_cur);
            end else if (roll < 11) begin
                t_cur += $urandom_range(0, dt_max * 4 + 3);
                push_plain(gbed_pkg::REQ_QUERY, t_cur);
            end else if (roll < 13) begin
                push_plain(gbed_pkg::REQ_CLEAR, t_cur);
            end else if (roll < 15) begin
                t_cur = $urandom;
                push_plain(gbed_pkg::REQ_STICK, t_cur);
            end else begin
                t_cur += $urandom_range(0, dt_max);
                kind = 2'($urandom_range(0, 2));
                inj  = 1'b1;
                tag  = foreign_tag();
                roll = $urandom_range(99);
                if (roll < 5)
                    kind = gbed_pkg::KIND_OTHER;
                else if (roll < 10)
                    inj = 1'b0;
                else if (roll < 15)
                    tag = m_own_tag;
                else if (roll < 20)
                    t_cur += $urandom_range(0, 70000);
                push_item(gbed_pkg::REQ_POINTER, t_cur, kind, inj, tag);
            end
        end
    endtask

    // driver: one transfer per cycle at most, payload held while stalled
    always @(posedge clk) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && !blk_stall) begin
                expected_results.push_back(predict_detect(drv_item));
                n_accepted <= n_accepted + 1;
            end
            if (!drv_valid || !blk_stall) begin
                if (pending_items.size() != 0 && (quiet() || $urandom_range(99) >= IDLE_PCT)) begin
                    drv_item  <= pending_items.pop_front();
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off that backs the block up
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_stall <= 1'b0;
        end else if (holdoff_left != 0) begin
            rx_stall     <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_done && n_accepted >= HOLDOFF_AT) begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            rx_stall     <= 1'b1;
        end else begin
            rx_stall <= !quiet() && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge clk) begin
        t_detect_result want;
        if (rst_n && res_valid && !rx_stall) begin
            n_results++;
            if (res_active === 1'b1)
                n_active++;
            if (res_hits > peak_hits)
                peak_hits = res_hits;
            if (expected_results.size() == 0) begin
                if (n_fail < 10)
                    $display("ERROR: result with nothing predicted: active=%0b hits=%0d",
                             res_active, res_hits);
                n_fail++;
            end else begin
                want = expected_results.pop_front();
                if (want.active !== res_active || want.hits !== res_hits) begin
                    if (n_fail < 10)
                        $display("ERROR: result %0d: active exp %0b got %0b, hits exp %0d got %0d",
                                 n_results, want.active, res_active, want.hits, res_hits);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        model_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults, block disabled
        n_settings++;
        push_item(gbed_pkg::REQ_POINTER, 32'd5, gbed_pkg::KIND_MOVE, 1'b1, 64'h1);
        wait_idle();
        write_reg(gbed_pkg::CFG_ENABLED, 64'd1);

        // enabled, no stick event seen yet
        push_item(gbed_pkg::REQ_POINTER, 32'd3, gbed_pkg::KIND_MOVE, 1'b1, 64'h5);
        push_plain(gbed_pkg::REQ_STICK, 32'd10);
        // hits join the window that starts at zero
        push_item(gbed_pkg::REQ_POINTER, 32'd20, gbed_pkg::KIND_MOVE, 1'b1, 64'h7);
        push_item(gbed_pkg::REQ_POINTER, 32'd25, gbed_pkg::KIND_WHEEL, 1'b1, 64'h8);
        push_item(gbed_pkg::REQ_POINTER, 32'd30, gbed_pkg::KIND_HWHEEL, 1'b1, 64'h9);
        push_item(gbed_pkg::REQ_POINTER, 32'd35, gbed_pkg::KIND_OTHER, 1'b1, 64'h9);
        push_item(gbed_pkg::REQ_POINTER, 32'd36, gbed_pkg::KIND_MOVE, 1'b0, 64'h9);
        push_item(gbed_pkg::REQ_POINTER, 32'd37, gbed_pkg::KIND_MOVE, 1'b1, 64'h0);
        push_item(gbed_pkg::REQ_POINTER, 32'd40, gbed_pkg::KIND_MOVE, 1'b1,
                  rand_tag() | 64'h1);
        push_item(gbed_pkg::REQ_POINTER, 32'd45, gbed_pkg::KIND_WHEEL, 1'b1, 64'h2);
        push_item(gbed_pkg::REQ_POINTER, 32'd50, gbed_pkg::KIND_MOVE, 1'b1, 64'h3);
        // hold time edge
        push_plain(gbed_pkg::REQ_QUERY, 32'd3050);
        push_plain(gbed_pkg::REQ_QUERY, 32'd3051);
        push_item(gbed_pkg::REQ_POINTER, 32'd3052, gbed_pkg::KIND_MOVE, 1'b1, 64'h3);
        push_plain(gbed_pkg::REQ_STICK, 32'd5000);
        // stale window
        push_item(gbed_pkg::REQ_POINTER, 32'd5100, gbed_pkg::KIND_MOVE, 1'b1, 64'h3);
        push_item(gbed_pkg::REQ_POINTER, 32'd5301, gbed_pkg::KIND_MOVE, 1'b1, 64'h3);
        push_plain(gbed_pkg::REQ_CLEAR, 32'd5302);
        push_plain(gbed_pkg::REQ_QUERY, 32'd5303);
        // time wraps between stick and pointer
        push_plain(gbed_pkg::REQ_STICK, 32'hFFFF_FFF0);
        push_item(gbed_pkg::REQ_POINTER, 32'h0000_0005, gbed_pkg::KIND_HWHEEL, 1'b1, 64'h3);
        push_item(gbed_pkg::REQ_POINTER, 32'h0000_0006, gbed_pkg::KIND_MOVE, 1'b1, '1);
        wait_idle();

        randomize_regs();
        t_cur = $urandom;
        gen_traffic(150, pace());
        wait_idle();

        // low extremes
        write_reg(gbed_pkg::CFG_GRACE_MS, 64'd0);
        write_reg(gbed_pkg::CFG_WINDOW_MS, 64'd1);
        write_reg(gbed_pkg::CFG_HITS_NEEDED, 64'd1);
        write_reg(gbed_pkg::CFG_HOLD_MS, 64'd0);
        write_reg(gbed_pkg::CFG_OWN_TAG, 64'd0);
        n_settings++;
        gen_traffic(80, pace());
        wait_idle();

        // high extremes, long burst to saturate the count
        write_reg(gbed_pkg::CFG_GRACE_MS, 64'd65535);
        write_reg(gbed_pkg::CFG_WINDOW_MS, 64'd65535);
        write_reg(gbed_pkg::CFG_HITS_NEEDED, 64'd255);
        write_reg(gbed_pkg::CFG_HOLD_MS, 64'd65535);
        write_reg(gbed_pkg::CFG_OWN_TAG, '1);
        n_settings++;
        t_cur = 32'hFFFF_F000;
        push_plain(gbed_pkg::REQ_STICK, t_cur);
        for (int k = 0; k < 270; k++) begin
            t_cur += $urandom_range(0, 2);
            push_item(gbed_pkg::REQ_POINTER, t_cur, 2'($urandom_range(0, 2)), 1'b1,
                      foreign_tag());
        end
        gen_traffic(60, 3);
        wait_idle();

        // zero threshold, near the wrap point
        randomize_regs();
        write_reg(gbed_pkg::CFG_HITS_NEEDED, 64'd0);
        t_cur = 32'hFFFF_FF00;
        gen_traffic(80, pace());
        wait_idle();

        // disabling clears; rewrites of the same value and unknown indexes do nothing
        write_reg(gbed_pkg::CFG_ENABLED, 64'd0);
        gen_traffic(15, pace());
        wait_idle();
        write_reg(gbed_pkg::CFG_ENABLED, {$urandom, $urandom} & ~64'd1);
        write_reg(gbed_pkg::CFG_ENABLED, 64'd1);
        write_reg(gbed_pkg::CFG_ENABLED, {$urandom, $urandom} | 64'd1);
        write_reg(CFG_SPARE_6, rand_tag());
        write_reg(CFG_SPARE_7, rand_tag());
        randomize_regs();
        gen_traffic(30, pace());
        wait_idle();

        if (expected_results.size() != 0)
            n_fail++;
        $display("%0d requests transferred under %0d register settings, %0d results checked",
                 n_accepted, n_settings, n_results);
        $display("%0d results showed a held detection, peak hit count %0d", n_active, peak_hits);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d failures", n_fail);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
